// ===== rtl/smc_pkg.sv =====
package smc_pkg;

    localparam int QueueDepth = 2;

    // Instruction phase codes.
    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_OP   = 3'd1;
    localparam logic [2:0] PH_S2   = 3'd2;
    localparam logic [2:0] PH_S3   = 3'd3;
    localparam logic [2:0] PH_S4   = 3'd4;
    localparam logic [2:0] PH_S5   = 3'd5;
    localparam logic [2:0] PH_CB   = 3'd7;

    typedef struct packed {
        logic [15:0] bus_addr;
        logic        bus_write;
        logic [7:0]  bus_wdata;
        logic        opcode_fetch;
        logic        unknown_op;
    } t_bus_req;

endpackage

// ===== rtl/smc_if.sv =====
interface smc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] bus_rdata;

    modport source (output valid, output bus_rdata, input ready);
    modport sink (input valid, input bus_rdata, output ready);
endinterface

interface smc_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] bus_addr;
    logic        bus_write;
    logic [7:0]  bus_wdata;
    logic        opcode_fetch;
    logic        unknown_op;

    modport source (output valid, output bus_addr, output bus_write, output bus_wdata,
                    output opcode_fetch, output unknown_op, input ready);
    modport sink (input valid, input bus_addr, input bus_write, input bus_wdata,
                  input opcode_fetch, input unknown_op, output ready);
endinterface

// ===== rtl/sm83_instruction_core.sv =====
// Bus-cycle core for a subset of the SM83 instruction set. Each input transfer completes
// one memory access and carries its read byte; each output transfer is the next access.
// Input transfers go into a two-entry queue; the execute stage takes one entry per clock
// whenever its output register is free or being drained, so the core sustains one access
// per cycle; each input passes the queue and then the output register. The register file,
// PC, SP and flags are updated in that single execute step; the first access after reset is
// an opcode fetch at address zero, and its input byte is ignored.
module sm83_instruction_core #(
    parameter int QDEPTH = smc_pkg::QueueDepth
) (
    input  logic i_clk,
    input  logic i_rst_n,
    smc_in_if.sink    i_in,
    smc_out_if.source o_out
);
    logic       q_valid, q_pop;
    logic [7:0] q_data;
    smc_pkg::t_bus_req req;

    smc_queue #(.DEPTH(QDEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in.valid),
        .i_data  (i_in.bus_rdata),
        .o_ready (i_in.ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    smc_exec u_exec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_rdata (q_data),
        .o_pop   (q_pop),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_req   (req)
    );

    assign o_out.bus_addr     = req.bus_addr;
    assign o_out.bus_write    = req.bus_write;
    assign o_out.bus_wdata    = req.bus_wdata;
    assign o_out.opcode_fetch = req.opcode_fetch;
    assign o_out.unknown_op   = req.unknown_op;
endmodule

// ===== rtl/smc_queue.sv =====
module smc_queue #(
    parameter int DEPTH = smc_pkg::QueueDepth
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic [7:0] i_data,
    output logic       o_ready,
    input  logic       i_pop,
    output logic       o_valid,
    output logic [7:0] o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [7:0]    r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;

    assign o_ready = (r_cnt < CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push && o_ready) begin
                r_mem[r_wp] <= i_data;
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
            end
            if (i_pop && o_valid) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
            end
            r_cnt <= r_cnt + CW'(i_push && o_ready) - CW'(i_pop && o_valid);
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt <= CW'(DEPTH))
        else $error("queue count exceeds depth");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0 && !i_push) |=> !o_valid)
        else $error("queue shows data it never received");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && o_ready && !(i_pop && o_valid)) |=> r_cnt == $past(r_cnt) + CW'(1))
        else $error("queue lost a transfer");
endmodule

// ===== rtl/smc_exec.sv =====
module smc_exec (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [7:0]        i_rdata,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output smc_pkg::t_bus_req o_req
);
    localparam logic [2:0] ALU_ADD = 3'd0, ALU_ADC = 3'd1, ALU_SUB = 3'd2, ALU_SBC = 3'd3;
    localparam logic [2:0] ALU_AND = 3'd4, ALU_XOR = 3'd5, ALU_OR = 3'd6, ALU_CP = 3'd7;
    localparam int F_Z = 3, F_C = 0;
    localparam logic [2:0] R_C = 3'd1, R_H = 3'd4, R_L = 3'd5, R_MEM = 3'd6, R_A = 3'd7;
    localparam logic [1:0] P_SP = 2'd3;

    localparam logic [7:0] OP_NOP      = 8'h00;
    localparam logic [7:0] OP_LD_SP_HL = 8'hf9;
    localparam logic [7:0] OP_HALT     = 8'h76;
    localparam logic [7:0] OP_LD_HL_N  = 8'h36;
    localparam logic [7:0] OP_LD_R_N   = 8'b00???110;
    localparam logic [7:0] OP_LD_R_R   = 8'b01??????;
    localparam logic [7:0] OP_ALU_R    = 8'b10??????;
    localparam logic [7:0] OP_LD_A_MEM = 8'b00??1010;
    localparam logic [7:0] OP_LDH_A_C  = 8'hf2;
    localparam logic [7:0] OP_LD_MEM_A = 8'b00??0010;
    localparam logic [7:0] OP_LDH_C_A  = 8'he2;
    localparam logic [7:0] OP_LDH_N_A  = 8'he0;
    localparam logic [7:0] OP_LDH_A_N  = 8'hf0;
    localparam logic [7:0] OP_LD_A_NN  = 8'hfa;
    localparam logic [7:0] OP_LD_NN_A  = 8'hea;
    localparam logic [7:0] OP_LD_NN_SP = 8'h08;
    localparam logic [7:0] OP_CALL     = 8'hcd;
    localparam logic [7:0] OP_LD_RR_NN = 8'b00??0001;
    localparam logic [7:0] OP_LD_HL_SPE = 8'hf8;
    localparam logic [7:0] OP_ADD_SP_E = 8'he8;
    localparam logic [7:0] OP_PUSH     = 8'b11??0101;
    localparam logic [7:0] OP_POP      = 8'b11??0001;
    localparam logic [7:0] OP_INC_HLM  = 8'h34;
    localparam logic [7:0] OP_DEC_HLM  = 8'h35;
    localparam logic [7:0] OP_INC_R    = 8'b00???100;
    localparam logic [7:0] OP_DEC_R    = 8'b00???101;
    localparam logic [7:0] OP_ADD_HL   = 8'b00??1001;
    localparam logic [7:0] OP_INC_RR   = 8'b00??0011;
    localparam logic [7:0] OP_DEC_RR   = 8'b00??1011;
    localparam logic [7:0] OP_SUB_N    = 8'hd6;
    localparam logic [7:0] OP_SBC_N    = 8'hde;
    localparam logic [7:0] OP_ALU_N    = 8'b11???110;
    localparam logic [7:0] OP_ROT_A    = 8'b000??111;
    localparam logic [7:0] OP_JR_NZ    = 8'h20;
    localparam logic [7:0] OP_RET      = 8'hc9;
    localparam logic [7:0] OP_RET_CC   = 8'b110??000;
    localparam logic [7:0] OP_PREFIX   = 8'hcb;
    localparam logic [1:0] ROT_RLC = 2'd0, ROT_RRC = 2'd1, ROT_RL = 2'd2, ROT_RR = 2'd3;
    localparam logic [7:0] OP_CB_SWAP  = 8'b00110???;
    localparam logic [7:0] OP_CB_RL_C  = 8'h11;
    localparam logic [7:0] OP_CB_BIT7H = 8'h7c;

    logic [7:0]  r_regs [8];
    logic [7:0]  n_regs [8];
    logic [3:0]  r_flags, n_flags;
    logic [15:0] r_pc, n_pc, r_sp, n_sp, r_tmp, n_tmp;
    logic [7:0]  r_op, n_op;
    logic        r_pfx, n_pfx, r_unk, n_unk;
    logic [2:0]  r_phase, n_phase;
    logic        r_ovalid;
    smc_pkg::t_bus_req r_req;

    logic        fire;
    logic [7:0]  d, op, acc, alu_b, idv, idr, sw_v, sw_r;
    logic [2:0]  k, rs, dst;
    logic [1:0]  p;
    logic [15:0] hl, rr_v, pr_v, push_v, lda, spe, tw;
    logic [11:0] alu_o;
    logic [16:0] add16;
    logic [12:0] add12;
    logic [4:0]  sph;
    logic [8:0]  spc;
    logic        b_wr, do_done, pfx, cond;
    logic [7:0]  b_wd;
    logic [15:0] b_addr;

    function automatic logic [11:0] f_alu(logic [2:0] grp, logic [7:0] a, logic [7:0] b,
                                          logic cf);
        logic       c;
        logic [8:0] s;
        logic [4:0] hs;
        logic [7:0] res;
        logic [3:0] fl;
        c   = (grp == ALU_ADC || grp == ALU_SBC) ? cf : 1'b0;
        s   = '0;
        hs  = '0;
        res = '0;
        fl  = '0;
        unique case (grp)
            ALU_ADD, ALU_ADC: begin
                s   = {1'b0, a} + {1'b0, b} + {8'b0, c};
                hs  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'b0, c};
                res = s[7:0];
                fl  = {2'b00, hs[4], s[8]};
            end
            ALU_SUB, ALU_SBC, ALU_CP: begin
                s   = {1'b0, a} - {1'b0, b} - {8'b0, c};
                res = s[7:0];
                fl  = {1'b0, 1'b1, ({1'b0, a[3:0]} < ({1'b0, b[3:0]} + {4'b0, c})),
                       ({1'b0, a} < ({1'b0, b} + {8'b0, c}))};
            end
            ALU_AND: begin
                res = a & b;
                fl  = 4'b0010;
            end
            ALU_XOR: res = a ^ b;
            ALU_OR:  res = a | b;
        endcase
        fl[F_Z] = (res == 8'h00);
        return {res, fl};
    endfunction

    assign fire    = i_valid && (!r_ovalid || i_ready);
    assign o_pop   = fire;
    assign o_valid = r_ovalid;
    assign o_req   = r_req;

    always_comb begin
        d   = i_rdata;
        k   = r_phase;
        op  = (k == smc_pkg::PH_OP || k == smc_pkg::PH_CB) ? d : r_op;
        pfx = (k == smc_pkg::PH_CB) ? 1'b1 : ((k == smc_pkg::PH_OP) ? 1'b0 : r_pfx);
        rs  = op[2:0];
        dst = op[5:3];
        p   = op[5:4];
        acc = r_regs[R_A];
        hl  = {r_regs[R_H], r_regs[R_L]};
        pr_v = {r_regs[{p, 1'b0}], r_regs[{p, 1'b1}]};
        rr_v = (p == P_SP) ? r_sp : pr_v;
        push_v = (p == P_SP) ? {acc, r_flags, 4'b0000} : pr_v;
        tw  = {d, r_tmp[7:0]};

        alu_b = (k == smc_pkg::PH_OP && rs != R_MEM) ? r_regs[rs] : d;
        alu_o = f_alu(dst, acc, alu_b, r_flags[F_C]);
        idv   = (op == OP_INC_HLM || op == OP_DEC_HLM) ? d : r_regs[dst];
        idr   = op[0] ? idv - 8'd1 : idv + 8'd1;
        sw_v  = (rs == R_MEM) ? d : r_regs[rs];
        sw_r  = {sw_v[3:0], sw_v[7:4]};
        add12 = {1'b0, hl[11:0]} + {1'b0, rr_v[11:0]};
        add16 = {1'b0, hl} + {1'b0, rr_v};
        sph   = {1'b0, r_sp[3:0]} + {1'b0, d[3:0]};
        spc   = {1'b0, r_sp[7:0]} + {1'b0, d};
        spe   = r_sp + {{8{d[7]}}, d};
        lda   = (op == OP_LDH_A_C || op == OP_LDH_C_A) ? {8'hff, r_regs[R_C]}
              : ((p >= 2'd2) ? hl : pr_v);
        unique case (op[4:3])
            2'd0:    cond = !r_flags[F_Z];
            2'd1:    cond = r_flags[F_Z];
            2'd2:    cond = !r_flags[F_C];
            default: cond = r_flags[F_C];
        endcase
        if (op == OP_RET) cond = 1'b1;

        n_regs  = r_regs;
        n_flags = r_flags;
        n_pc    = r_pc;
        n_sp    = r_sp;
        n_tmp   = r_tmp;
        n_op    = op;
        n_pfx   = pfx;
        n_unk   = (k == smc_pkg::PH_OP || k == smc_pkg::PH_CB) ? 1'b0 : r_unk;
        n_phase = r_phase;
        b_addr  = '0;
        b_wr    = 1'b0;
        b_wd    = '0;
        do_done = 1'b0;

        if (k == smc_pkg::PH_IDLE) begin
            do_done = 1'b1;
        end else if (pfx) begin
            priority casez (op)
                OP_CB_SWAP: begin
                    if (rs != R_MEM) begin
                        n_regs[rs] = sw_r;
                        n_flags = {(sw_r == 8'h00), 3'b000};
                        do_done = 1'b1;
                    end else if (k == smc_pkg::PH_CB) begin
                        b_addr = hl; n_phase = smc_pkg::PH_S2;
                    end else if (k == smc_pkg::PH_S2) begin
                        n_flags = {(sw_r == 8'h00), 3'b000};
                        b_addr = hl; b_wr = 1'b1; b_wd = sw_r; n_phase = smc_pkg::PH_S3;
                    end else begin
                        do_done = 1'b1;
                    end
                end
                OP_CB_RL_C: begin
                    n_regs[R_C] = {r_regs[R_C][6:0], r_flags[F_C]};
                    n_flags = {({r_regs[R_C][6:0], r_flags[F_C]} == 8'h00), 2'b00,
                               r_regs[R_C][7]};
                    do_done = 1'b1;
                end
                OP_CB_BIT7H: begin
                    n_flags = {!r_regs[R_H][7], 1'b0, 1'b1, r_flags[F_C]};
                    do_done = 1'b1;
                end
                default: begin
                    n_unk = 1'b1; do_done = 1'b1;
                end
            endcase
        end else begin
            priority casez (op)
                OP_HALT, OP_SUB_N, OP_SBC_N: begin
                    n_unk = 1'b1; do_done = 1'b1;
                end
                OP_LD_R_R: begin
                    if (rs == R_MEM) begin
                        if (k == smc_pkg::PH_OP) begin
                            b_addr = hl; n_phase = smc_pkg::PH_S2;
                        end else begin
                            n_regs[dst] = d; do_done = 1'b1;
                        end
                    end else if (dst == R_MEM) begin
                        if (k == smc_pkg::PH_OP) begin
                            b_addr = hl; b_wr = 1'b1; b_wd = r_regs[rs];
                            n_phase = smc_pkg::PH_S2;
                        end else begin
                            do_done = 1'b1;
                        end
                    end else begin
                        n_regs[dst] = r_regs[rs]; do_done = 1'b1;
                    end
                end
                OP_ALU_R: begin
                    if (rs == R_MEM && k == smc_pkg::PH_OP) begin
                        b_addr = hl; n_phase = smc_pkg::PH_S2;
                    end else begin
                        n_flags = alu_o[3:0];
                        if (dst != ALU_CP) n_regs[R_A] = alu_o[11:4];
                        do_done = 1'b1;
                    end
                end
                OP_ALU_N: begin
                    if (k == smc_pkg::PH_OP) begin
                        b_addr = r_pc; n_pc = r_pc + 16'd1; n_phase = smc_pkg::PH_S2;
                    end else begin
                        n_flags = alu_o[3:0];
                        if (dst != ALU_CP) n_regs[R_A] = alu_o[11:4];
                        do_done = 1'b1;
                    end
                end
                OP_NOP: do_done = 1'b1;
                OP_LD_SP_HL: begin
                    n_sp = hl; do_done = 1'b1;
                end
                OP_LD_HL_N: begin
                    if (k == smc_pkg::PH_OP) begin
                        b_addr = r_pc; n_pc = r_pc + 16'd1; n_phase = smc_pkg::PH_S2;
                    end else if (k == smc_pkg::PH_S2) begin
                        b_addr = hl; b_wr = 1'b1; b_wd = d; n_phase = smc_pkg::PH_S3;
                    end else begin
                        do_done = 1'b1;
                    end
                end
                OP_LD_R_N: begin
                    if (k == smc_pkg::PH_OP) begin
                        b_addr = r_pc; n_pc = r_pc + 16'd1; n_phase = smc_pkg::PH_S2;
                    end else begin
                        n_regs[dst] = d; do_done = 1'b1;
                    end
                end
                OP_LD_A_MEM, OP_LDH_A_C: begin
                    if (k == smc_pkg::PH_OP) begin
                        b_addr = lda; n_phase = smc_pkg::PH_S2;
                        if (op != OP_LDH_A_C && p == 2'd2) {n_regs[R_H], n_regs[R_L]} = hl + 16'd1;
                        if (op != OP_LDH_A_C && p == 2'd3) {n_regs[R_H], n_regs[R_L]} = hl - 16'd1;
                    end else begin
                        n_regs[R_A] = d; do_done = 1'b1;
                    end
                end
                OP_LD_MEM_A, OP_LDH_C_A: begin
                    if (k == smc_pkg::PH_OP) begin
                        b_addr = lda; b_wr = 1'b1; b_wd = acc; n_phase = smc_pkg::PH_S2;
                        if (op != OP_LDH_C_A && p == 2'd2) {n_regs[R_H], n_regs[R_L]} = hl + 16'd1;
                        if (op != OP_LDH_C_A && p == 2'd3) {n_regs[R_H], n_regs[R_L]} = hl - 16'd1;
                    end else begin
                        do_done = 1'b1;
                    end
                end
                OP_LDH_N_A: begin
                    if (k == smc_pkg::PH_OP) begin
                        b_addr = r_pc; n_pc = r_pc + 16'd1; n_phase = smc_pkg::PH_S2;
                    end else if (k == smc_pkg::PH_S2) begin
                        b_addr = {8'hff, d}; b_wr = 1'b1; b_wd = acc; n_phase = smc_pkg::PH_S3;
                    end else begin
                        do_done = 1'b1;
                    end
                end
                OP_LDH_A_N: begin
                    if (k == smc_pkg::PH_OP) begin
                        b_addr = r_pc; n_pc = r_pc + 16'd1; n_phase = smc_pkg::PH_S2;
                    end else if (k == smc_pkg::PH_S2) begin
                        b_addr = {8'hff, d}; n_phase = smc_pkg::PH_S3;
                    end else begin
                        n_regs[R_A] = d; do_done = 1'b1;
                    end
                end
                OP_LD_A_NN, OP_LD_NN_A, OP_LD_NN_SP, OP_CALL: begin
                    if (k == smc_pkg::PH_OP) begin
                        b_addr = r_pc; n_pc = r_pc + 16'd1; n_phase = smc_pkg::PH_S2;
                    end else if (k == smc_pkg::PH_S2) begin
                        n_tmp = {8'h00, d};
                        b_addr = r_pc; n_pc = r_pc + 16'd1; n_phase = smc_pkg::PH_S3;
                    end else if (k == smc_pkg::PH_S3) begin
                        n_tmp = tw;
                        n_phase = smc_pkg::PH_S4;
                        if (op == OP_LD_A_NN) begin
                            b_addr = tw;
                        end else if (op == OP_LD_NN_A) begin
                            b_addr = tw; b_wr = 1'b1; b_wd = acc;
                        end else if (op == OP_LD_NN_SP) begin
                            b_addr = tw; b_wr = 1'b1; b_wd = r_sp[7:0];
                        end else begin
                            n_sp = r_sp - 16'd1;
                            b_addr = r_sp - 16'd1; b_wr = 1'b1; b_wd = r_pc[15:8];
                        end
                    end else if (k == smc_pkg::PH_S4 && op == OP_LD_NN_SP) begin
                        b_addr = r_tmp + 16'd1; b_wr = 1'b1; b_wd = r_sp[15:8];
                        n_phase = smc_pkg::PH_S5;
                    end else if (k == smc_pkg::PH_S4 && op == OP_CALL) begin
                        n_sp = r_sp - 16'd1;
                        b_addr = r_sp - 16'd1; b_wr = 1'b1; b_wd = r_pc[7:0];
                        n_phase = smc_pkg::PH_S5;
                    end else begin
                        if (op == OP_LD_A_NN) n_regs[R_A] = d;
                        if (op == OP_CALL) n_pc = r_tmp;
                        do_done = 1'b1;
                    end
                end
                OP_LD_RR_NN: begin
                    if (k == smc_pkg::PH_OP) begin
                        b_addr = r_pc; n_pc = r_pc + 16'd1; n_phase = smc_pkg::PH_S2;
                    end else if (k == smc_pkg::PH_S2) begin
                        n_tmp = {8'h00, d};
                        b_addr = r_pc; n_pc = r_pc + 16'd1; n_phase = smc_pkg::PH_S3;
                    end else begin
                        if (p == P_SP) n_sp = tw;
                        else {n_regs[{p, 1'b0}], n_regs[{p, 1'b1}]} = tw;
                        do_done = 1'b1;
                    end
                end
                OP_LD_HL_SPE, OP_ADD_SP_E: begin
                    if (k == smc_pkg::PH_OP) begin
                        b_addr = r_pc; n_pc = r_pc + 16'd1; n_phase = smc_pkg::PH_S2;
                    end else begin
                        n_flags = {2'b00, sph[4], spc[8]};
                        if (op == OP_LD_HL_SPE) {n_regs[R_H], n_regs[R_L]} = spe;
                        else n_sp = spe;
                        do_done = 1'b1;
                    end
                end
                OP_PUSH: begin
                    if (k == smc_pkg::PH_OP) begin
                        n_sp = r_sp - 16'd1;
                        b_addr = r_sp - 16'd1; b_wr = 1'b1; b_wd = push_v[15:8];
                        n_phase = smc_pkg::PH_S2;
                    end else if (k == smc_pkg::PH_S2) begin
                        n_sp = r_sp - 16'd1;
                        b_addr = r_sp - 16'd1; b_wr = 1'b1; b_wd = push_v[7:0];
                        n_phase = smc_pkg::PH_S3;
                    end else begin
                        do_done = 1'b1;
                    end
                end
                OP_POP: begin
                    if (k == smc_pkg::PH_OP) begin
                        b_addr = r_sp; n_sp = r_sp + 16'd1; n_phase = smc_pkg::PH_S2;
                    end else if (k == smc_pkg::PH_S2) begin
                        n_tmp = {8'h00, d};
                        b_addr = r_sp; n_sp = r_sp + 16'd1; n_phase = smc_pkg::PH_S3;
                    end else begin
                        if (p == P_SP) begin
                            n_regs[R_A] = d; n_flags = r_tmp[7:4];
                        end else begin
                            {n_regs[{p, 1'b0}], n_regs[{p, 1'b1}]} = tw;
                        end
                        do_done = 1'b1;
                    end
                end
                OP_INC_HLM, OP_DEC_HLM: begin
                    if (k == smc_pkg::PH_OP) begin
                        b_addr = hl; n_phase = smc_pkg::PH_S2;
                    end else if (k == smc_pkg::PH_S2) begin
                        n_flags = {(idr == 8'h00), op[0],
                                   op[0] ? (idv[3:0] == 4'h0) : (idv[3:0] == 4'hf), r_flags[F_C]};
                        b_addr = hl; b_wr = 1'b1; b_wd = idr; n_phase = smc_pkg::PH_S3;
                    end else begin
                        do_done = 1'b1;
                    end
                end
                OP_INC_R, OP_DEC_R: begin
                    n_regs[dst] = idr;
                    n_flags = {(idr == 8'h00), op[0],
                               op[0] ? (idv[3:0] == 4'h0) : (idv[3:0] == 4'hf), r_flags[F_C]};
                    do_done = 1'b1;
                end
                OP_ADD_HL: begin
                    n_flags = {r_flags[F_Z], 1'b0, add12[12], add16[16]};
                    {n_regs[R_H], n_regs[R_L]} = add16[15:0];
                    do_done = 1'b1;
                end
                OP_INC_RR, OP_DEC_RR: begin
                    if (p == P_SP) n_sp = op[3] ? rr_v - 16'd1 : rr_v + 16'd1;
                    else {n_regs[{p, 1'b0}], n_regs[{p, 1'b1}]} =
                        op[3] ? rr_v - 16'd1 : rr_v + 16'd1;
                    do_done = 1'b1;
                end
                OP_ROT_A: begin
                    unique case (op[4:3])
                        ROT_RLC: begin
                            n_regs[R_A] = {acc[6:0], acc[7]}; n_flags = {3'b000, acc[7]};
                        end
                        ROT_RRC: begin
                            n_regs[R_A] = {acc[0], acc[7:1]}; n_flags = {3'b000, acc[0]};
                        end
                        ROT_RL: begin
                            n_regs[R_A] = {acc[6:0], r_flags[F_C]}; n_flags = {3'b000, acc[7]};
                        end
                        default: begin
                            n_regs[R_A] = {r_flags[F_C], acc[7:1]}; n_flags = {3'b000, acc[0]};
                        end
                    endcase
                    do_done = 1'b1;
                end
                OP_JR_NZ: begin
                    if (k == smc_pkg::PH_OP) begin
                        b_addr = r_pc; n_pc = r_pc + 16'd1; n_phase = smc_pkg::PH_S2;
                    end else begin
                        if (!r_flags[F_Z]) n_pc = r_pc + {{8{d[7]}}, d};
                        do_done = 1'b1;
                    end
                end
                OP_RET, OP_RET_CC: begin
                    if (k == smc_pkg::PH_OP) begin
                        if (cond) begin
                            b_addr = r_sp; n_sp = r_sp + 16'd1; n_phase = smc_pkg::PH_S2;
                        end else begin
                            do_done = 1'b1;
                        end
                    end else if (k == smc_pkg::PH_S2) begin
                        n_tmp = {8'h00, d};
                        b_addr = r_sp; n_sp = r_sp + 16'd1; n_phase = smc_pkg::PH_S3;
                    end else begin
                        n_pc = tw; do_done = 1'b1;
                    end
                end
                OP_PREFIX: begin
                    b_addr = r_pc; n_pc = r_pc + 16'd1; n_phase = smc_pkg::PH_CB;
                end
                default: begin
                    n_unk = 1'b1; do_done = 1'b1;
                end
            endcase
        end

        // Finishing an instruction issues the next opcode fetch from the updated PC.
        if (do_done) begin
            b_addr  = n_pc;
            b_wr    = 1'b0;
            b_wd    = '0;
            n_pc    = n_pc + 16'd1;
            n_phase = smc_pkg::PH_OP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) r_regs[i] <= '0;
            r_flags  <= '0;
            r_pc     <= '0;
            r_sp     <= '0;
            r_tmp    <= '0;
            r_op     <= '0;
            r_pfx    <= 1'b0;
            r_unk    <= 1'b0;
            r_phase  <= smc_pkg::PH_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (fire) begin
                r_regs  <= n_regs;
                r_flags <= n_flags;
                r_pc    <= n_pc;
                r_sp    <= n_sp;
                r_tmp   <= n_tmp;
                r_op    <= n_op;
                r_pfx   <= n_pfx;
                r_unk   <= n_unk;
                r_phase <= n_phase;
                r_req   <= '{bus_addr: b_addr, bus_write: b_wr, bus_wdata: b_wd,
                             opcode_fetch: do_done, unknown_op: n_unk};
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_phase != 3'd6)
        else $error("unused instruction phase reached");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_req.opcode_fetch) |-> r_phase == smc_pkg::PH_OP)
        else $error("opcode fetch issued without phase returning to opcode");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) fire |=> r_ovalid)
        else $error("executed step produced no access");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !r_req.bus_write) |-> r_req.bus_wdata == 8'h00)
        else $error("read access carries write data");
endmodule

// ===== tb/tb_sm83_instruction_core.sv =====
module tb_sm83_instruction_core;

    logic i_clk;
    logic i_rst_n;

    smc_in_if  in_if ();
    smc_out_if out_if ();

    sm83_instruction_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Shadow copy of the core state.
    logic [7:0]  cpu_reg [8];
    logic [3:0]  cpu_flags;
    logic [15:0] cpu_pc;
    logic [15:0] cpu_sp;
    logic [15:0] cpu_tmp;
    logic [7:0]  cpu_opcode;
    logic        cpu_prefixed;
    logic        cpu_unknown;
    logic [2:0]  cpu_phase;
    smc_pkg::t_bus_req next_access;

    smc_pkg::t_bus_req access_queue[$];
    int       error_count;
    int       item_count;
    int       result_count;
    int       fetch_count;
    int       write_count;
    bit       no_idle;
    bit       hold_request;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #5000000;
        $display("Timeout after %0d transfers", result_count);
        $display("Some tests failed");
        $finish;
    end

    function automatic logic [15:0] get_pair(int hi);
        return {cpu_reg[hi], cpu_reg[hi + 1]};
    endfunction

    task automatic put_pair(int hi, logic [15:0] v);
        cpu_reg[hi]     = v[15:8];
        cpu_reg[hi + 1] = v[7:0];
    endtask

    function automatic logic [15:0] get_rr(int p);
        return (p == 3) ? cpu_sp : get_pair(p * 2);
    endfunction

    task automatic put_rr(int p, logic [15:0] v);
        if (p == 3) cpu_sp = v;
        else put_pair(p * 2, v);
    endtask

    task automatic issue(logic [15:0] addr, logic wr, logic [7:0] wd, logic [2:0] nph);
        next_access.bus_addr     = addr;
        next_access.bus_write    = wr;
        next_access.bus_wdata    = wr ? wd : 8'h00;
        next_access.opcode_fetch = 1'b0;
        cpu_phase = nph;
    endtask

    task automatic read_pc(logic [2:0] nph);
        issue(cpu_pc, 1'b0, 8'h00, nph);
        cpu_pc = cpu_pc + 16'd1;
    endtask

    task automatic fetch_next();
        next_access.bus_addr     = cpu_pc;
        next_access.bus_write    = 1'b0;
        next_access.bus_wdata    = 8'h00;
        next_access.opcode_fetch = 1'b1;
        cpu_pc = cpu_pc + 16'd1;
        cpu_phase = smc_pkg::PH_OP;
    endtask

    task automatic do_alu(int grp, logic [7:0] opnd);
        int acc, b, cin, res;
        logic [3:0] f;
        acc = int'(cpu_reg[7]);
        b = int'(opnd);
        cin = (grp == 1 || grp == 3) ? int'(cpu_flags[0]) : 0;
        f = 4'b0000;
        if (grp <= 1) begin
            res = acc + b + cin;
            f[1] = ((acc & 15) + (b & 15) + cin) > 15;
            f[0] = res > 255;
        end else if (grp == 2 || grp == 3 || grp == 7) begin
            res = acc - b - cin;
            f[2] = 1'b1;
            f[1] = (acc & 15) < (b & 15) + cin;
            f[0] = acc < b + cin;
        end else if (grp == 4) begin
            res = acc & b;
            f[1] = 1'b1;
        end else if (grp == 5) begin
            res = acc ^ b;
        end else begin
            res = acc | b;
        end
        res = res & 255;
        if (res == 0) f[3] = 1'b1;
        cpu_flags = f;
        if (grp != 7) cpu_reg[7] = res[7:0];
    endtask

    task automatic inc_byte(logic [7:0] v, output logic [7:0] r);
        r = v + 8'd1;
        cpu_flags = {r == 8'h00, 1'b0, v[3:0] == 4'hf, cpu_flags[0]};
    endtask

    task automatic dec_byte(logic [7:0] v, output logic [7:0] r);
        r = v - 8'd1;
        cpu_flags = {r == 8'h00, 1'b1, v[3:0] == 4'h0, cpu_flags[0]};
    endtask

    task automatic swap_nibbles(logic [7:0] v, output logic [7:0] r);
        r = {v[3:0], v[7:4]};
        cpu_flags = {r == 8'h00, 3'b000};
    endtask

    task automatic prefixed_op(int k, logic [7:0] d);
        logic [7:0] op, v, r;
        op = cpu_opcode;
        if (op >= 8'h30 && op <= 8'h37) begin
            if (op[2:0] != 3'd6) begin
                swap_nibbles(cpu_reg[op[2:0]], r);
                cpu_reg[op[2:0]] = r;
                fetch_next();
            end else if (k == 1) begin
                issue(get_pair(4), 1'b0, 8'h00, smc_pkg::PH_S2);
            end else if (k == 2) begin
                swap_nibbles(d, r);
                issue(get_pair(4), 1'b1, r, smc_pkg::PH_S3);
            end else begin
                fetch_next();
            end
        end else if (op == 8'h11) begin
            v = cpu_reg[1];
            cpu_reg[1] = {v[6:0], cpu_flags[0]};
            cpu_flags = {cpu_reg[1] == 8'h00, 2'b00, v[7]};
            fetch_next();
        end else if (op == 8'h7c) begin
            cpu_flags = {~cpu_reg[4][7], 1'b0, 1'b1, cpu_flags[0]};
            fetch_next();
        end else begin
            cpu_unknown = 1'b1;
            fetch_next();
        end
    endtask

    function automatic bit ret_taken(logic [7:0] op);
        case (op)
            8'hc0: return !cpu_flags[3];
            8'hc8: return cpu_flags[3];
            8'hd0: return !cpu_flags[0];
            8'hd8: return cpu_flags[0];
            default: return 1'b1;
        endcase
    endfunction

    task automatic main_op(int k, logic [7:0] d);
        logic [7:0]  op, r8;
        logic [2:0]  src, dst;
        int          p;
        logic [15:0] hl, v, addr;
        logic [12:0] sum12;
        logic [16:0] sum17;
        op = cpu_opcode;
        src = op[2:0];
        dst = op[5:3];
        p = int'(op[5:4]);
        hl = get_pair(4);
        if (op >= 8'h40 && op <= 8'h7f && op != 8'h76) begin
            if (src == 3'd6) begin
                if (k == 1) issue(hl, 1'b0, 8'h00, smc_pkg::PH_S2);
                else begin cpu_reg[dst] = d; fetch_next(); end
            end else if (dst == 3'd6) begin
                if (k == 1) issue(hl, 1'b1, cpu_reg[src], smc_pkg::PH_S2);
                else fetch_next();
            end else begin
                cpu_reg[dst] = cpu_reg[src];
                fetch_next();
            end
        end else if (op >= 8'h80 && op <= 8'hbf) begin
            if (src != 3'd6) begin
                do_alu(int'(dst), cpu_reg[src]);
                fetch_next();
            end else if (k == 1) begin
                issue(hl, 1'b0, 8'h00, smc_pkg::PH_S2);
            end else begin
                do_alu(int'(dst), d);
                fetch_next();
            end
        end else begin
            case (op)
                8'h00, 8'hf9: begin
                    if (op == 8'hf9) cpu_sp = hl;
                    fetch_next();
                end
                8'h06, 8'h0e, 8'h16, 8'h1e, 8'h26, 8'h2e, 8'h3e: begin
                    if (k == 1) read_pc(smc_pkg::PH_S2);
                    else begin cpu_reg[dst] = d; fetch_next(); end
                end
                8'h36: begin
                    if (k == 1) read_pc(smc_pkg::PH_S2);
                    else if (k == 2) issue(hl, 1'b1, d, smc_pkg::PH_S3);
                    else fetch_next();
                end
                8'h0a, 8'h1a, 8'h2a, 8'h3a, 8'hf2: begin
                    if (k == 1) begin
                        if (op == 8'hf2) addr = {8'hff, cpu_reg[1]};
                        else if (op >= 8'h2a) addr = hl;
                        else addr = get_pair(p * 2);
                        issue(addr, 1'b0, 8'h00, smc_pkg::PH_S2);
                        if (op == 8'h2a) put_pair(4, hl + 16'd1);
                        if (op == 8'h3a) put_pair(4, hl - 16'd1);
                    end else begin
                        cpu_reg[7] = d;
                        fetch_next();
                    end
                end
                8'h02, 8'h12, 8'h22, 8'h32, 8'he2: begin
                    if (k == 1) begin
                        if (op == 8'he2) addr = {8'hff, cpu_reg[1]};
                        else if (op >= 8'h22) addr = hl;
                        else addr = get_pair(p * 2);
                        issue(addr, 1'b1, cpu_reg[7], smc_pkg::PH_S2);
                        if (op == 8'h22) put_pair(4, hl + 16'd1);
                        if (op == 8'h32) put_pair(4, hl - 16'd1);
                    end else begin
                        fetch_next();
                    end
                end
                8'he0: begin
                    if (k == 1) read_pc(smc_pkg::PH_S2);
                    else if (k == 2) issue({8'hff, d}, 1'b1, cpu_reg[7], smc_pkg::PH_S3);
                    else fetch_next();
                end
                8'hf0: begin
                    if (k == 1) read_pc(smc_pkg::PH_S2);
                    else if (k == 2) issue({8'hff, d}, 1'b0, 8'h00, smc_pkg::PH_S3);
                    else begin cpu_reg[7] = d; fetch_next(); end
                end
                8'hfa, 8'hea, 8'h08, 8'hcd: begin
                    if (k == 1) begin
                        read_pc(smc_pkg::PH_S2);
                    end else if (k == 2) begin
                        cpu_tmp = {8'h00, d};
                        read_pc(smc_pkg::PH_S3);
                    end else if (k == 3) begin
                        cpu_tmp[15:8] = d;
                        if (op == 8'hfa) issue(cpu_tmp, 1'b0, 8'h00, smc_pkg::PH_S4);
                        else if (op == 8'hea) issue(cpu_tmp, 1'b1, cpu_reg[7], smc_pkg::PH_S4);
                        else if (op == 8'h08) issue(cpu_tmp, 1'b1, cpu_sp[7:0], smc_pkg::PH_S4);
                        else begin
                            cpu_sp = cpu_sp - 16'd1;
                            issue(cpu_sp, 1'b1, cpu_pc[15:8], smc_pkg::PH_S4);
                        end
                    end else if (k == 4 && op == 8'h08) begin
                        issue(cpu_tmp + 16'd1, 1'b1, cpu_sp[15:8], smc_pkg::PH_S5);
                    end else if (k == 4 && op == 8'hcd) begin
                        cpu_sp = cpu_sp - 16'd1;
                        issue(cpu_sp, 1'b1, cpu_pc[7:0], smc_pkg::PH_S5);
                    end else begin
                        if (op == 8'hfa) cpu_reg[7] = d;
                        if (op == 8'hcd) cpu_pc = cpu_tmp;
                        fetch_next();
                    end
                end
                8'h01, 8'h11, 8'h21, 8'h31: begin
                    if (k == 1) read_pc(smc_pkg::PH_S2);
                    else if (k == 2) begin cpu_tmp = {8'h00, d}; read_pc(smc_pkg::PH_S3); end
                    else begin put_rr(p, {d, cpu_tmp[7:0]}); fetch_next(); end
                end
                8'hf8, 8'he8: begin
                    if (k == 1) begin
                        read_pc(smc_pkg::PH_S2);
                    end else begin
                        cpu_flags = {2'b00,
                                     (int'(cpu_sp[3:0]) + int'(d[3:0])) > 15,
                                     (int'(cpu_sp[7:0]) + int'(d)) > 255};
                        v = cpu_sp + {{8{d[7]}}, d};
                        if (op == 8'hf8) put_pair(4, v);
                        else cpu_sp = v;
                        fetch_next();
                    end
                end
                8'hc5, 8'hd5, 8'he5, 8'hf5: begin
                    v = (p == 3) ? {cpu_reg[7], cpu_flags, 4'h0} : get_pair(p * 2);
                    if (k == 1) begin
                        cpu_sp = cpu_sp - 16'd1;
                        issue(cpu_sp, 1'b1, v[15:8], smc_pkg::PH_S2);
                    end else if (k == 2) begin
                        cpu_sp = cpu_sp - 16'd1;
                        issue(cpu_sp, 1'b1, v[7:0], smc_pkg::PH_S3);
                    end else begin
                        fetch_next();
                    end
                end
                8'hc1, 8'hd1, 8'he1, 8'hf1: begin
                    if (k == 1) begin
                        issue(cpu_sp, 1'b0, 8'h00, smc_pkg::PH_S2);
                        cpu_sp = cpu_sp + 16'd1;
                    end else if (k == 2) begin
                        cpu_tmp = {8'h00, d};
                        issue(cpu_sp, 1'b0, 8'h00, smc_pkg::PH_S3);
                        cpu_sp = cpu_sp + 16'd1;
                    end else begin
                        if (p == 3) begin
                            cpu_reg[7] = d;
                            cpu_flags = cpu_tmp[7:4];
                        end else begin
                            put_pair(p * 2, {d, cpu_tmp[7:0]});
                        end
                        fetch_next();
                    end
                end
                8'h04, 8'h0c, 8'h14, 8'h1c, 8'h24, 8'h2c, 8'h3c: begin
                    inc_byte(cpu_reg[dst], r8);
                    cpu_reg[dst] = r8;
                    fetch_next();
                end
                8'h05, 8'h0d, 8'h15, 8'h1d, 8'h25, 8'h2d, 8'h3d: begin
                    dec_byte(cpu_reg[dst], r8);
                    cpu_reg[dst] = r8;
                    fetch_next();
                end
                8'h34, 8'h35: begin
                    if (k == 1) issue(hl, 1'b0, 8'h00, smc_pkg::PH_S2);
                    else if (k == 2) begin
                        if (op == 8'h34) inc_byte(d, r8);
                        else dec_byte(d, r8);
                        issue(hl, 1'b1, r8, smc_pkg::PH_S3);
                    end else fetch_next();
                end
                8'h09, 8'h19, 8'h29, 8'h39: begin
                    v = get_rr(p);
                    sum12 = {1'b0, hl[11:0]} + {1'b0, v[11:0]};
                    sum17 = {1'b0, hl} + {1'b0, v};
                    cpu_flags = {cpu_flags[3], 1'b0, sum12[12], sum17[16]};
                    put_pair(4, hl + v);
                    fetch_next();
                end
                8'h03, 8'h13, 8'h23, 8'h33: begin
                    put_rr(p, get_rr(p) + 16'd1);
                    fetch_next();
                end
                8'h0b, 8'h1b, 8'h2b, 8'h3b: begin
                    put_rr(p, get_rr(p) - 16'd1);
                    fetch_next();
                end
                8'hc6, 8'hce, 8'he6, 8'hee, 8'hf6, 8'hfe: begin
                    if (k == 1) read_pc(smc_pkg::PH_S2);
                    else begin do_alu(int'(dst), d); fetch_next(); end
                end
                8'h07, 8'h0f, 8'h17, 8'h1f: begin
                    r8 = cpu_reg[7];
                    case (op)
                        8'h07: begin cpu_flags = {3'b000, r8[7]}; r8 = {r8[6:0], r8[7]}; end
                        8'h0f: begin cpu_flags = {3'b000, r8[0]}; r8 = {r8[0], r8[7:1]}; end
                        8'h17: begin
                            r8 = {r8[6:0], cpu_flags[0]};
                            cpu_flags = {3'b000, cpu_reg[7][7]};
                        end
                        default: begin
                            r8 = {cpu_flags[0], r8[7:1]};
                            cpu_flags = {3'b000, cpu_reg[7][0]};
                        end
                    endcase
                    cpu_reg[7] = r8;
                    fetch_next();
                end
                8'h20: begin
                    if (k == 1) read_pc(smc_pkg::PH_S2);
                    else begin
                        if (!cpu_flags[3]) cpu_pc = cpu_pc + {{8{d[7]}}, d};
                        fetch_next();
                    end
                end
                8'hc9, 8'hc0, 8'hc8, 8'hd0, 8'hd8: begin
                    if (k == 1) begin
                        if (ret_taken(op)) begin
                            issue(cpu_sp, 1'b0, 8'h00, smc_pkg::PH_S2);
                            cpu_sp = cpu_sp + 16'd1;
                        end else begin
                            fetch_next();
                        end
                    end else if (k == 2) begin
                        cpu_tmp = {8'h00, d};
                        issue(cpu_sp, 1'b0, 8'h00, smc_pkg::PH_S3);
                        cpu_sp = cpu_sp + 16'd1;
                    end else begin
                        cpu_pc = {d, cpu_tmp[7:0]};
                        fetch_next();
                    end
                end
                8'hcb: read_pc(smc_pkg::PH_CB);
                default: begin
                    cpu_unknown = 1'b1;
                    fetch_next();
                end
            endcase
        end
    endtask

    task automatic advance_core(logic [7:0] d);
        logic [2:0] ph;
        ph = cpu_phase;
        if (ph == smc_pkg::PH_IDLE) begin
            fetch_next();
        end else if (ph == smc_pkg::PH_OP) begin
            cpu_opcode = d;
            cpu_prefixed = 1'b0;
            cpu_unknown = 1'b0;
            main_op(1, d);
        end else if (ph == smc_pkg::PH_CB) begin
            cpu_opcode = d;
            cpu_prefixed = 1'b1;
            cpu_unknown = 1'b0;
            prefixed_op(1, d);
        end else if (cpu_prefixed) begin
            prefixed_op(int'(ph), d);
        end else begin
            main_op(int'(ph), d);
        end
        next_access.unknown_op = cpu_unknown;
        access_queue.push_back(next_access);
    endtask

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 25);
    endfunction

    // One input transfer; valid stays high across back-to-back items.
    task automatic send_byte(logic [7:0] b);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.bus_rdata <= b;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        item_count++;
        advance_core(b);
    endtask

    // Random bytes, biased toward a list of opcodes and of CB opcodes.
    function automatic logic [7:0] pick_byte();
        logic [7:0] favored [12] = '{8'hcd, 8'hc9, 8'hc0, 8'hc8, 8'hd0, 8'hd8,
                                     8'h20, 8'hcb, 8'hf5, 8'hf1, 8'h08, 8'h76};
        logic [7:0] cb_ops [10] = '{8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35,
                                    8'h36, 8'h37, 8'h11, 8'h7c};
        int r;
        r = $urandom_range(0, 99);
        if (cpu_phase == smc_pkg::PH_OP && r < 25) return favored[$urandom_range(0, 11)];
        if (cpu_phase == smc_pkg::PH_CB && r < 60) return cb_ops[$urandom_range(0, 9)];
        if (r < 5) return 8'h00;
        if (r < 10) return 8'hff;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic report(string field, logic [15:0] got, logic [15:0] want);
        error_count++;
        $display("Mismatch on transfer %0d: %s is %h, expected %h",
                 result_count, field, got, want);
    endtask

    // Result side: compare, then choose ready for the next cycle.
    int stall_left;
    int hold_left;
    always @(posedge i_clk) begin
        smc_pkg::t_bus_req want;
        if (out_if.valid && out_if.ready) begin
            result_count++;
            if (access_queue.size() == 0) begin
                report("unexpected transfer", out_if.bus_addr, 16'h0000);
            end else begin
                want = access_queue.pop_front();
                if (out_if.bus_write) write_count++;
                if (out_if.opcode_fetch) fetch_count++;
                if (out_if.bus_addr !== want.bus_addr)
                    report("bus_addr", out_if.bus_addr, want.bus_addr);
                if (out_if.bus_write !== want.bus_write)
                    report("bus_write", 16'(out_if.bus_write), 16'(want.bus_write));
                if (out_if.bus_wdata !== want.bus_wdata)
                    report("bus_wdata", 16'(out_if.bus_wdata), 16'(want.bus_wdata));
                if (out_if.opcode_fetch !== want.opcode_fetch)
                    report("opcode_fetch", 16'(out_if.opcode_fetch),
                           16'(want.opcode_fetch));
                if (out_if.unknown_op !== want.unknown_op)
                    report("unknown_op", 16'(out_if.unknown_op), 16'(want.unknown_op));
            end
        end
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left = 120;
        end
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            out_if.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            out_if.ready <= 1'b0;
        end else begin
            stall_left = idle_gap();
            out_if.ready <= (stall_left == 0);
        end
    end

    task automatic test_directed();
        logic [7:0] prog [] = '{
            8'h00,                          // ignored byte of the first access
            8'h31, 8'hfe, 8'hff,            // LD SP,0xfffe
            8'h3e, 8'hff,                   // LD A,0xff
            8'hc6, 8'h01,                   // ADD A,1: zero, half carry, carry
            8'hcd, 8'h34, 8'h12, 8'h00, 8'h00,  // CALL, two stack writes
            8'hc9, 8'h02, 8'h00,            // RET to 0x0002
            8'h76,                          // HALT is not implemented
            8'hcb, 8'h37,                   // SWAP A
            8'hcb, 8'h00,                   // unimplemented prefixed op
            8'h20, 8'h80,                   // JR NZ backwards, not taken as Z is set
            8'hf5, 8'h00, 8'h00,            // PUSH AF
            8'hd6                           // SUB n is not implemented
        };
        foreach (prog[i]) send_byte(prog[i]);
    endtask

    task automatic test_random(int n);
        repeat (n) send_byte(pick_byte());
    endtask

    // Receiver holds off while input keeps coming, filling the queue.
    task automatic test_backpressure();
        no_idle = 1'b1;
        hold_request = 1'b1;
        repeat (60) send_byte(pick_byte());
        no_idle = 1'b0;
    endtask

    task automatic test_streaming();
        no_idle = 1'b1;
        repeat (200) send_byte(pick_byte());
        no_idle = 1'b0;
    endtask

    task automatic drain();
        int waited;
        in_if.valid <= 1'b0;
        waited = 0;
        while (access_queue.size() != 0) begin
            @(posedge i_clk);
            waited++;
            if (waited > 200000) begin
                $display("Results still missing: %0d", access_queue.size());
                $display("Some tests failed");
                $finish;
            end
        end
        repeat (10) @(posedge i_clk);
    endtask

    initial begin
        in_if.valid     <= 1'b0;
        in_if.bus_rdata <= 8'h00;
        i_rst_n         <= 1'b0;
        foreach (cpu_reg[i]) cpu_reg[i] = 8'h00;
        cpu_flags = 4'h0;
        cpu_pc = 16'h0000;
        cpu_sp = 16'h0000;
        cpu_tmp = 16'h0000;
        cpu_opcode = 8'h00;
        cpu_prefixed = 1'b0;
        cpu_unknown = 1'b0;
        cpu_phase = smc_pkg::PH_IDLE;
        next_access = '0;
        error_count = 0;
        item_count = 0;
        result_count = 0;
        fetch_count = 0;
        write_count = 0;
        no_idle = 1'b0;
        hold_request = 1'b0;
        stall_left = 0;
        hold_left = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(900);
        test_backpressure();
        test_streaming();
        test_random(700);
        drain();

        $display("Ran %0d bus transfers: %0d opcode fetches, %0d writes,",
                 result_count, fetch_count, write_count);
        $display("with random stalls on both sides and one long result hold-off.");
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/smc_pkg.sv
rtl/smc_if.sv
rtl/smc_queue.sv
rtl/smc_exec.sv
rtl/sm83_instruction_core.sv
tb/tb_sm83_instruction_core.sv
